/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, disabled while reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define BB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true
`define BB_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* design/bbcg_pkg.sv */
// ----------------------------------------------------------------------------
// bbcg_pkg
// types and constants of the bandpass beam coefficient generator
// ----------------------------------------------------------------------------
package bbcg_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_POLE_RADIUS   = 2'd0;
  localparam logic [1:0] REG_SPACING_RATIO = 2'd1;
  localparam logic [1:0] REG_SENSOR_COUNT  = 2'd2;

  localparam logic [14:0] POLE_RADIUS_RST   = 15'd29491;
  localparam logic [14:0] SPACING_RATIO_RST = 15'd8192;
  localparam logic [6:0]  SENSOR_COUNT_RST  = 7'd8;

  typedef struct packed {
    logic [14:0] pole_radius;
    logic [14:0] spacing_ratio;
    logic [6:0]  sensor_count;
  } cfg_t;

  // classified request handed from the front to the engine
  typedef struct packed {
    logic [15:0] mag;
    logic        neg;
    logic [6:0]  count;
  } cmd_t;

  typedef struct packed {
    logic [5:0]         coef_index;
    logic signed [23:0] coef_value;
    logic               saturated;
    logic               last_coef;
  } res_t;

endpackage

/* design/beam_bandpass_coefficient_gen_top.sv */
// ----------------------------------------------------------------------------
// beam_bandpass_coefficient_gen_top
// one steering angle in, one saturated Q8.15 coefficient per sensor out
// ----------------------------------------------------------------------------
// the one shared multiplier steps both sine/cosine series and the recurrence, so the
// engine takes no new angle until the last coefficient of the current one is pushed
// a two-deep request queue and a two-deep result queue part the sides
// reset: asynchronous, active low; queues empty, registers at defaults
module beam_bandpass_coefficient_gen_top
  import bbcg_pkg::*;
#(
  parameter int MAX_SENSORS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] steer_angle_i,
  output logic               empty,
  input  logic               pop,
  output logic [5:0]         coef_index_o,
  output logic signed [23:0] coef_value_o,
  output logic               saturated_o,
  output logic               last_coef_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [14:0]        cfg_data_i
);

  cfg_t cfg_q;
  cmd_t cmd;
  res_t res, res_out;
  logic cmd_valid, cmd_pop, res_full, res_push;
  logic [$bits(res_t)-1:0] res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pole_radius   <= POLE_RADIUS_RST;
      cfg_q.spacing_ratio <= SPACING_RATIO_RST;
      cfg_q.sensor_count  <= SENSOR_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLE_RADIUS:   cfg_q.pole_radius   <= cfg_data_i;
        REG_SPACING_RATIO: cfg_q.spacing_ratio <= cfg_data_i;
        REG_SENSOR_COUNT:  cfg_q.sensor_count  <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  bbcg_front #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .steer_angle_i  (steer_angle_i),
    .sensor_count_i (cfg_q.sensor_count),
    .cmd_pop_i      (cmd_pop),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd)
  );

  bbcg_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  bbcg_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_data),
    .empty_o (empty)
  );

  assign res_out      = res_t'(res_data);
  assign coef_index_o = res_out.coef_index;
  assign coef_value_o = res_out.coef_value;
  assign saturated_o  = res_out.saturated;
  assign last_coef_o  = res_out.last_coef;

endmodule

/* design/bbcg_fifo.sv */
// ----------------------------------------------------------------------------
// bbcg_fifo
// small first-word-fall-through register queue
// ----------------------------------------------------------------------------
module bbcg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/bbcg_front.sv */
// ----------------------------------------------------------------------------
// bbcg_front
// takes steering angles, splits sign and magnitude, clamps the sensor count
// and queues the request for the engine
// ----------------------------------------------------------------------------
module bbcg_front
  import bbcg_pkg::*;
#(
  parameter int MAX_SENSORS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] steer_angle_i,
  input  logic [6:0]  sensor_count_i,
  input  logic        cmd_pop_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o
);

  localparam logic [6:0] MaxCount = 7'(MAX_SENSORS);

  cmd_t cmd_in;
  logic q_empty;
  logic [$bits(cmd_t)-1:0] q_data;

  always_comb begin
    cmd_in.neg   = steer_angle_i[15];
    cmd_in.mag   = steer_angle_i[15] ? 16'(17'h10000 - {1'b0, steer_angle_i}) : steer_angle_i;
    cmd_in.count = (sensor_count_i > MaxCount) ? MaxCount : sensor_count_i;
  end

  // a zero count produces nothing, so the request is dropped here
  bbcg_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && (cmd_in.count != 7'd0)),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = cmd_t'(q_data);

endmodule

/* design/bbcg_engine.sv */
// ----------------------------------------------------------------------------
// bbcg_engine
// sequencer around one shared multiplier: angle to phase, two sine/cosine
// series, then the resonator recurrence, one coefficient per sensor
// ----------------------------------------------------------------------------
module bbcg_engine
  import bbcg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

`include "assert_macros.svh"

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PM0  = 5'd1;
  localparam logic [4:0] S_PM1  = 5'd2;
  localparam logic [4:0] S_PM2  = 5'd3;
  localparam logic [4:0] S_DV0  = 5'd4;
  localparam logic [4:0] S_DV1  = 5'd5;
  localparam logic [4:0] S_DV2  = 5'd6;
  localparam logic [4:0] S_SC0  = 5'd7;
  localparam logic [4:0] S_SC1  = 5'd8;
  localparam logic [4:0] S_SC2  = 5'd9;
  localparam logic [4:0] S_SC3  = 5'd10;
  localparam logic [4:0] S_H0   = 5'd11;
  localparam logic [4:0] S_H1   = 5'd12;
  localparam logic [4:0] S_H2   = 5'd13;
  localparam logic [4:0] S_SS0  = 5'd14;
  localparam logic [4:0] S_SS1  = 5'd15;
  localparam logic [4:0] S_SCE  = 5'd16;
  localparam logic [4:0] S_PH0  = 5'd17;
  localparam logic [4:0] S_PH1  = 5'd18;
  localparam logic [4:0] S_A0   = 5'd19;
  localparam logic [4:0] S_A1   = 5'd20;
  localparam logic [4:0] S_K0   = 5'd21;
  localparam logic [4:0] S_K1   = 5'd22;
  localparam logic [4:0] S_K2   = 5'd23;
  localparam logic [4:0] S_K3   = 5'd24;
  localparam logic [4:0] S_K4   = 5'd25;
  localparam logic [4:0] S_K5   = 5'd26;
  localparam logic [4:0] S_K6   = 5'd27;
  localparam logic [4:0] S_K7   = 5'd28;

  // divisor selection codes
  localparam logic [3:0] DIV_45       = 4'd0;
  localparam logic [3:0] DIV_SIN_BASE = 4'd1;
  localparam logic [3:0] DIV_COS_BASE = 4'd5;

  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [31:0] HALF_PI  = 32'd1686629713;
  localparam logic [31:0] MAG_MUL  = 32'd46603;
  localparam logic [32:0] U_INIT   = 33'h0_0100_0000;
  localparam logic signed [67:0] OUT_MAX = 68'sd8388607;
  localparam logic signed [67:0] OUT_MIN = -68'sd8388608;

  // divisor and floor(2^32 / divisor)
  function automatic logic [63:0] div_const(input logic [3:0] idx);
    logic [63:0] r;
    case (idx)
      4'd0:    r = {32'd45, 32'd95443717};
      4'd1:    r = {32'd72, 32'd59652323};
      4'd2:    r = {32'd42, 32'd102261126};
      4'd3:    r = {32'd20, 32'd214748364};
      4'd4:    r = {32'd6,  32'd715827882};
      4'd5:    r = {32'd90, 32'd47721858};
      4'd6:    r = {32'd56, 32'd76695844};
      4'd7:    r = {32'd30, 32'd143165576};
      4'd8:    r = {32'd12, 32'd357913941};
      4'd9:    r = {32'd2,  32'd2147483648};
      default: r = {32'd1,  32'd0};
    endcase
    return r;
  endfunction

  // signed rescale, rounding half away from zero
  function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] v,
                                                   input logic [5:0] n);
    logic [67:0] mag;
    logic [67:0] m;
    mag = v[67] ? 68'(-v) : 68'(v);
    m   = (mag + (68'd1 << (n - 6'd1))) >> n;
    return v[67] ? -$signed(m) : $signed(m);
  endfunction

  logic [4:0] state_q, state_d, ret_q, ret_d;
  logic [5:0] k_q, k_d;

  logic               mul_en;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_q;

  logic [15:0] mag_q;
  logic        neg_q;
  logic [6:0]  n_q;
  logic [31:0] div_v_q, div_q0_q, div_res_q;
  logic [3:0]  div_idx_q;
  logic [31:0] phase_q;
  logic [2:0]  oct_q, j_q;
  logic [29:0] x_q, x2_q;
  logic [30:0] ser_q, sraw_q, smag_q, a_q, rk_q;
  logic        cos_q, pass_q;
  logic signed [32:0] t_q, u_prev_q, u_cur_q, v_q, vkm1_q, vkm2_q;
  logic signed [33:0] diff_q;

  logic [31:0] div_d, div_m, div_rem, pm;
  logic [29:0] f_ext;
  logic [59:0] x_sum;
  logic [45:0] rk_sum;
  logic [63:0] ph_sum;
  logic [2:0]  oct_p1, oct_p2;
  logic [30:0] sv_m, cv_m;
  logic signed [31:0] sv, cv;
  logic signed [67:0] r30, w;
  logic        is_last, w_hi, w_lo;

  assign {div_d, div_m} = div_const(div_idx_q);
  assign div_rem = div_v_q - prod_q[31:0];
  assign pm      = prod_q[31:0] + div_res_q;
  assign f_ext   = phase_q[29] ? (30'h2000_0000 - {1'b0, phase_q[28:0]}) : {1'b0, phase_q[28:0]};
  assign x_sum   = prod_q[59:0] + 60'h2000_0000;
  assign rk_sum  = prod_q[45:0] + 46'h4000;
  assign ph_sum  = prod_q[63:0] + 64'd2048;
  assign r30     = rnd_shift(prod_q, 6'd30);
  assign w       = rnd_shift(prod_q, 6'd39);
  assign is_last = ({1'b0, k_q} == (n_q - 7'd1));

  // octant symmetry
  assign oct_p1 = oct_q + 3'd1;
  assign oct_p2 = oct_q + 3'd2;
  assign sv_m   = oct_p1[1] ? ser_q : sraw_q;
  assign cv_m   = oct_p1[1] ? sraw_q : ser_q;
  assign sv     = oct_q[2] ? -$signed({1'b0, sv_m}) : $signed({1'b0, sv_m});
  assign cv     = oct_p2[2] ? -$signed({1'b0, cv_m}) : $signed({1'b0, cv_m});

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_DV0: begin
        mul_en = 1'b1;
        mul_a  = 34'(div_v_q);
        mul_b  = 34'(div_m);
      end
      S_DV1: begin
        mul_en = 1'b1;
        mul_a  = 34'(prod_q[63:32]);
        mul_b  = 34'(div_d);
      end
      S_PM1: begin
        mul_en = 1'b1;
        mul_a  = 34'(mag_q);
        mul_b  = 34'(MAG_MUL);
      end
      S_SC0: begin
        mul_en = 1'b1;
        mul_a  = 34'(f_ext);
        mul_b  = 34'(HALF_PI);
      end
      S_SC2: begin
        mul_en = 1'b1;
        mul_a  = 34'(x_q);
        mul_b  = 34'(x_q);
      end
      S_H0: begin
        mul_en = 1'b1;
        mul_a  = 34'(x2_q);
        mul_b  = 34'(ser_q);
      end
      S_SS0: begin
        mul_en = 1'b1;
        mul_a  = 34'(x_q);
        mul_b  = 34'(ser_q);
      end
      S_PH0: begin
        mul_en = 1'b1;
        mul_a  = 34'(cfg_i.spacing_ratio);
        mul_b  = 34'(smag_q);
      end
      S_A0: begin
        mul_en = 1'b1;
        mul_a  = 34'(cfg_i.pole_radius);
        mul_b  = 34'(cfg_i.pole_radius);
      end
      S_K0: begin
        mul_en = 1'b1;
        mul_a  = 34'(rk_q);
        mul_b  = 34'(cfg_i.pole_radius);
      end
      S_K1: begin
        mul_en = 1'b1;
        mul_a  = 34'(t_q);
        mul_b  = 34'(u_cur_q);
      end
      S_K3: begin
        mul_en = 1'b1;
        mul_a  = 34'(rk_q);
        mul_b  = 34'(u_cur_q);
      end
      S_K6: begin
        mul_en = 1'b1;
        mul_a  = 34'(a_q);
        mul_b  = diff_q;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // control sequencer
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    k_d        = k_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = S_PM0;
        end
      end
      S_PM0: begin
        ret_d   = S_PM1;
        state_d = S_DV0;
      end
      S_DV0: state_d = S_DV1;
      S_DV1: state_d = S_DV2;
      S_DV2: state_d = ret_q;
      S_PM1: state_d = S_PM2;
      S_PM2: state_d = S_SC0;
      S_SC0: state_d = S_SC1;
      S_SC1: state_d = S_SC2;
      S_SC2: state_d = S_SC3;
      S_SC3: state_d = S_H0;
      S_H0:  state_d = S_H1;
      S_H1: begin
        ret_d   = S_H2;
        state_d = S_DV0;
      end
      S_H2: begin
        if (!cos_q && (j_q == 3'd3)) begin
          state_d = S_SS0;
        end else if (cos_q && (j_q == 3'd4)) begin
          state_d = S_SCE;
        end else begin
          state_d = S_H0;
        end
      end
      S_SS0: state_d = S_SS1;
      S_SS1: state_d = S_H0;
      S_SCE: state_d = pass_q ? S_A0 : S_PH0;
      S_PH0: state_d = S_PH1;
      S_PH1: state_d = S_SC0;
      S_A0:  state_d = S_A1;
      S_A1: begin
        k_d     = '0;
        state_d = S_K3;
      end
      S_K0: state_d = S_K1;
      S_K1: state_d = S_K2;
      S_K2: state_d = S_K3;
      S_K3: state_d = S_K4;
      S_K4: state_d = S_K5;
      S_K5: state_d = S_K6;
      S_K6: state_d = S_K7;
      S_K7: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + 6'd1;
            state_d = S_K0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      k_q     <= k_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        mag_q <= cmd_i.mag;
        neg_q <= cmd_i.neg;
        n_q   <= cmd_i.count;
      end
      S_PM0: begin
        // remainder part of mag * 2^21 / 45
        div_v_q   <= 32'({mag_q, 4'b0000}) + 32'(mag_q) + 32'd22;
        div_idx_q <= DIV_45;
      end
      S_DV1: div_q0_q <= prod_q[63:32];
      S_DV2: div_res_q <= div_q0_q + 32'(div_rem >= div_d);
      S_PM2: begin
        phase_q <= neg_q ? (32'd0 - pm) : pm;
        pass_q  <= 1'b0;
      end
      S_SC0: oct_q <= phase_q[31:29];
      S_SC1: x_q <= x_sum[59:30];
      S_SC3: begin
        x2_q  <= prod_q[59:30];
        ser_q <= Q30_ONE;
        j_q   <= '0;
        cos_q <= 1'b0;
      end
      S_H1: begin
        div_v_q   <= prod_q[61:30];
        div_idx_q <= (cos_q ? DIV_COS_BASE : DIV_SIN_BASE) + {1'b0, j_q};
      end
      S_H2: begin
        ser_q <= Q30_ONE - div_res_q[30:0];
        j_q   <= j_q + 3'd1;
      end
      S_SS1: begin
        sraw_q <= prod_q[60:30];
        ser_q  <= Q30_ONE;
        j_q    <= '0;
        cos_q  <= 1'b1;
      end
      S_SCE: begin
        if (pass_q) begin
          t_q <= {cv, 1'b0};
        end else begin
          smag_q <= sv[31] ? 31'(-sv) : sv[30:0];
        end
      end
      S_PH1: begin
        phase_q <= ph_sum[43:12];
        pass_q  <= 1'b1;
      end
      S_A0: begin
        rk_q     <= Q30_ONE;
        u_prev_q <= '0;
        u_cur_q  <= U_INIT;
        vkm1_q   <= '0;
        vkm2_q   <= '0;
      end
      S_A1: a_q <= Q30_ONE - {1'b0, prod_q[29:0]};
      S_K1: rk_q <= rk_sum[45:15];
      S_K2: begin
        u_cur_q  <= 33'(r30) - u_prev_q;
        u_prev_q <= u_cur_q;
      end
      S_K4: v_q <= 33'(r30);
      S_K5: diff_q <= 34'(v_q) - ((k_q >= 6'd2) ? 34'(vkm2_q) : 34'sd0);
      S_K7: begin
        if (!res_full_i) begin
          vkm2_q <= vkm1_q;
          vkm1_q <= v_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign w_hi = (w > OUT_MAX);
  assign w_lo = (w < OUT_MIN);

  always_comb begin
    res_o.coef_index = k_q;
    res_o.saturated  = w_hi || w_lo;
    res_o.last_coef  = is_last;
    if (w_hi) begin
      res_o.coef_value = 24'sh7F_FFFF;
    end else if (w_lo) begin
      res_o.coef_value = 24'sh80_0000;
    end else begin
      res_o.coef_value = w[23:0];
    end
  end

  `BB_ASSERT(a_k_in_range, (state_q == S_K7) |-> ({1'b0, k_q} < n_q), "sensor index past count")
  `BB_ASSERT(a_last_idle, (res_push_o && res_o.last_coef) |=> (state_q == S_IDLE), "run did not end")
  `BB_ASSERT(a_pop_start, cmd_pop_o |=> (state_q == S_PM0), "request taken while busy")
  `BB_ASSERT_NEVER(a_push_full, res_push_o && res_full_i, "result pushed into full queue")

endmodule

/* verif/bbcg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbcg_checker
// watches the angle, coefficient and register ports of the beam coefficient
// generator, predicts every coefficient of each accepted angle and compares
// the transfers on the result side in order, field by field
// ----------------------------------------------------------------------------
module bbcg_checker
  import bbcg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic signed [15:0] steer_angle_i,
  input  logic               empty,
  input  logic               pop,
  input  logic [5:0]         coef_index_o,
  input  logic signed [23:0] coef_value_o,
  input  logic               saturated_o,
  input  logic               last_coef_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [14:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam longint ONE_Q30 = 64'sd1073741824;

  cfg_t cfg_q;
  res_t coef_queue[$];

  assign pending_o = coef_queue.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  // signed rescale, half away from zero
  function automatic longint rnd_shift(input longint v, input int n);
    longint half;
    half = longint'(1) << (n - 1);
    if (v < 0) return -(((-v) + half) >>> n);
    return (v + half) >>> n;
  endfunction

  function automatic void sin_cos(input bit [31:0] phase, output longint sv, output longint cv);
    bit [2:0]  oct;
    bit [63:0] f, x, x2, s, c;
    longint    tmp;
    oct = phase[31:29];
    f   = {35'd0, phase[28:0]};
    if (oct[0]) f = (64'd1 << 29) - f;
    x  = (f * 64'd1686629713 + (64'd1 << 29)) >> 30;
    x2 = (x * x) >> 30;
    s = ONE_Q30 - x2 / 72;
    s = ONE_Q30 - ((x2 * s) >> 30) / 42;
    s = ONE_Q30 - ((x2 * s) >> 30) / 20;
    s = ONE_Q30 - ((x2 * s) >> 30) / 6;
    s = (x * s) >> 30;
    c = ONE_Q30 - x2 / 90;
    c = ONE_Q30 - ((x2 * c) >> 30) / 56;
    c = ONE_Q30 - ((x2 * c) >> 30) / 30;
    c = ONE_Q30 - ((x2 * c) >> 30) / 12;
    c = ONE_Q30 - ((x2 * c) >> 30) / 2;
    sv = longint'(s);
    cv = longint'(c);
    if (((oct + 3'd1) & 3'd2) != 0) begin
      tmp = sv; sv = cv; cv = tmp;
    end
    if (oct[2]) sv = -sv;
    if (((oct + 3'd2) & 3'd4) != 0) cv = -cv;
  endfunction

  function automatic void predict_coefs(input logic [15:0] angle);
    bit        neg;
    bit [63:0] mag, pmag, smag, rk;
    bit [31:0] pang, pphi;
    longint    st, ct, sp, cp, t, a, u_prev, u_cur, u_next, v, v1, v2, w;
    int        n;
    res_t      r;
    neg  = angle[15];
    mag  = neg ? 64'h10000 - angle : {48'd0, angle};
    pmag = ((mag << 32) + 64'd46080) / 64'd92160;
    pang = neg ? 32'(-pmag) : pmag[31:0];
    a    = ONE_Q30 - longint'(cfg_q.pole_radius) * longint'(cfg_q.pole_radius);
    n    = (cfg_q.sensor_count > 64) ? 64 : int'(cfg_q.sensor_count);
    sin_cos(pang, st, ct);
    smag = (st < 0) ? -st : st;
    pphi = 32'((64'(cfg_q.spacing_ratio) * smag + 64'd2048) >> 12);
    sin_cos(pphi, sp, cp);
    t = 2 * cp;
    u_prev = 0;
    u_cur  = longint'(1) << 24;
    v1 = 0;
    v2 = 0;
    rk = ONE_Q30;
    for (int k = 0; k < n; k++) begin
      if (k > 0) begin
        rk = (rk * cfg_q.pole_radius + 64'd16384) >> 15;
        u_next = rnd_shift(t * u_cur, 30) - u_prev;
        u_prev = u_cur;
        u_cur  = u_next;
      end
      v = rnd_shift(longint'(rk) * u_cur, 30);
      w = rnd_shift(a * (v - ((k >= 2) ? v2 : 0)), 39);
      v2 = v1;
      v1 = v;
      r.saturated = 1'b0;
      if (w > 8388607) begin
        w = 8388607; r.saturated = 1'b1;
      end else if (w < -8388608) begin
        w = -8388608; r.saturated = 1'b1;
      end
      r.coef_index = 6'(k);
      r.coef_value = 24'(w);
      r.last_coef  = (k + 1 == n);
      coef_queue.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      cfg_q <= '{POLE_RADIUS_RST, SPACING_RATIO_RST, SENSOR_COUNT_RST};
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POLE_RADIUS:   cfg_q.pole_radius   <= cfg_data_i;
          REG_SPACING_RATIO: cfg_q.spacing_ratio <= cfg_data_i;
          REG_SENSOR_COUNT:  cfg_q.sensor_count  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (push && !full) predict_coefs(steer_angle_i);
      if (pop && !empty) begin
        if (coef_queue.size() == 0) begin
          report_mismatch("unexpected coef_index", coef_index_o, -1);
        end else begin
          e = coef_queue.pop_front();
          if (coef_index_o !== e.coef_index)
            report_mismatch("coef_index", coef_index_o, e.coef_index);
          if (coef_value_o !== e.coef_value)
            report_mismatch("coef_value", coef_value_o, e.coef_value);
          if (saturated_o !== e.saturated)
            report_mismatch("saturated", saturated_o, e.saturated);
          if (last_coef_o !== e.last_coef)
            report_mismatch("last_coef", last_coef_o, e.last_coef);
        end
      end
    end
  end

  initial fail_count_o = 0;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives steering angles and register settings into the beam coefficient
// generator with random gaps and result stalls; the checker predicts and
// compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb
  import bbcg_pkg::*;
();

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic signed [15:0] steer_angle_i;
  logic               empty;
  logic               pop;
  logic [5:0]         coef_index_o;
  logic signed [23:0] coef_value_o;
  logic               saturated_o;
  logic               last_coef_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [14:0]        cfg_data_i;
  int                 fail_count;
  int                 pending;
  bit                 steady;

  beam_bandpass_coefficient_gen_top u_dut (.*);

  bbcg_checker u_chk (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("FAIL beam_bandpass_coefficient_gen_top");
    $finish;
  end

  // result side stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pop <= 1'b0;
    else pop <= steady || ($urandom_range(0, 99) >= 35);
  end

  task automatic send_angle(input logic [15:0] angle);
    bit ok;
    while (!steady && $urandom_range(0, 99) < 35) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    steer_angle_i <= angle;
    do begin
      @(negedge clk_i);
      ok = !full;
      @(posedge clk_i);
    end while (!ok);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // wait for every coefficient to be taken, then let the bench idle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic setup(input logic [14:0] r, input logic [14:0] sp, input logic [6:0] n);
    write_reg(REG_POLE_RADIUS, r);
    write_reg(REG_SPACING_RATIO, sp);
    write_reg(REG_SENSOR_COUNT, {8'd0, n});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return 16'(int'($urandom_range(0, 46080)) - 23040);
  endfunction

  initial begin
    logic [15:0] dir_angles[] = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd1, -16'sd1,
                                  16'sd11520, -16'sd7680, 16'sd32767, 16'h8000,
                                  16'd46079, 16'sd5760};
    push          = 1'b0;
    steer_angle_i = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_POLE_RADIUS;
    cfg_data_i    = '0;
    steady        = 1'b0;
    rst_ni        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings first
    foreach (dir_angles[i]) send_angle(dir_angles[i]);
    drain();
    // largest radius, spacing and count
    setup(15'h7FFF, 15'h7FFF, 7'd64);
    send_angle(16'sd23040);
    send_angle(-16'sd3000);
    send_angle(16'sd0);
    drain();
    // zero radius, zero spacing, count clamped above the maximum
    setup(15'd0, 15'd0, 7'd127);
    send_angle(16'sd9000);
    send_angle(-16'sd20000);
    drain();
    // zero count gives nothing; index beyond the list is ignored
    setup(15'd16384, 15'd16384, 7'd0);
    write_reg(2'd3, 15'h7FFF);
    cfg_we_i <= 1'b0;
    send_angle(16'sd4000);
    send_angle(-16'sd23040);
    drain();
    setup(15'd30000, 15'd16384, 7'd1);
    send_angle(16'sd11520);
    send_angle(-16'sd11520);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      setup(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
            (ph == 9) ? 7'd64 : 7'($urandom_range(0, 12)));
      steady = (ph == 5);
      for (int i = 0; i < 20; i++) send_angle(rand_angle());
      drain();
    end
    steady = 1'b0;

    if (fail_count == 0) begin
      $display("PASS beam_bandpass_coefficient_gen_top");
    end else begin
      $display("FAIL beam_bandpass_coefficient_gen_top");
    end
    $finish;
  end

endmodule
